/* sv/stsum_pkg.sv */
// Shared types and constants for the segment tree range sum block.
// No dependencies; every other file imports this package.
package stsum_pkg;

  localparam int DATA_W           = 32;
  localparam int IDX_IN_W         = 10;
  localparam int CFG_W            = 11;
  localparam int MAX_ELEMENTS_DEF = 1024;

  localparam logic ACT_SET   = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef struct packed {
    logic                       action;
    logic [IDX_IN_W-1:0]        first_index;
    logic [IDX_IN_W-1:0]        last_index;
    logic signed [DATA_W-1:0]   new_value;
  } stsum_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]   range_sum;
    logic                       bad_index;
  } stsum_out_t;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  typedef enum logic {
    WALK_PATH  = 1'b0,
    WALK_QUERY = 1'b1
  } walk_mode_t;

  typedef struct packed {
    logic       load;
    walk_mode_t mode;
  } walk_cmd_t;

  typedef struct packed {
    logic emit;
    logic last;
  } walk_stat_t;

endpackage

/* sv/segment_tree_range_sum_top.sv */
// Segment tree range sum: element store, node-sum memory, sequencer.
// Depends on stsum_pkg, stsum_alu and stsum_walk.
// A flagged or reversed item strobes its result in the cycle after start; a set
// passes through S_DIFF, S_WALK and S_DRAIN; a query walks S_WALK and S_DRAIN,
// reading the node memory one node at a time on one port. busy stays high until
// the result strobe of a set or a walked query (a flagged or reversed item leaves
// busy low), so one item is in flight at a time. Results strobe for one cycle and
// cannot be stalled. After rst_n the node memory and element store are swept to
// zero with busy high; config writes are taken throughout.
module segment_tree_range_sum_top #(
  parameter int MAX_ELEMENTS = stsum_pkg::MAX_ELEMENTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  stsum_pkg::stsum_in_t             in_data,
  output logic                             out_valid,
  output stsum_pkg::stsum_out_t            out_data,
  input  logic                             cfg_we,
  input  logic [stsum_pkg::CFG_W-1:0]      cfg_wdata
);
  import stsum_pkg::*;

  localparam int LH_W       = $clog2(MAX_ELEMENTS);
  localparam int K_W        = LH_W + 1;
  localparam int NODE_DEPTH = 2 ** K_W;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_DIFF  = 5'b00100,
    S_WALK  = 5'b01000,
    S_DRAIN = 5'b10000
  } state_t;

  // storage
  logic [DATA_W-1:0] elem_mem [MAX_ELEMENTS];
  logic [DATA_W-1:0] node_mem [NODE_DEPTH];

  state_t            state_r, state_nxt;
  logic [K_W-1:0]    clr_cnt_r, clr_cnt_nxt;
  logic [CFG_W-1:0]  cfg_size_r;
  stsum_in_t         item_r, item_nxt;
  logic [DATA_W-1:0] elem_q_r;
  logic [DATA_W-1:0] node_q_r;
  logic              rd_vld_r;
  logic [K_W-1:0]    wr_addr_r;
  logic [DATA_W-1:0] diff_r, diff_nxt;
  logic [DATA_W-1:0] acc_r, acc_nxt;
  logic              out_valid_r, out_valid_nxt;
  stsum_out_t        out_data_r, out_data_nxt;

  logic              accept;
  logic [CFG_W-1:0]  n_eff;
  logic [LH_W-1:0]   top_hi;
  logic              first_bad, last_bad, item_bad, reversed;
  logic              item_is_set;
  walk_cmd_t         w_cmd;
  walk_stat_t        w_stat;
  logic [K_W-1:0]    w_node;
  logic [LH_W-1:0]   w_ql, w_qr;
  alu_op_t           alu_op;
  logic [DATA_W-1:0] alu_a, alu_b, alu_y;

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // clamp the size register: zero acts as one, above capacity acts as capacity
  always_comb begin
    if (cfg_size_r == '0) begin
      n_eff = CFG_W'(1);
    end else if (32'(cfg_size_r) > MAX_ELEMENTS) begin
      n_eff = CFG_W'(MAX_ELEMENTS);
    end else begin
      n_eff = cfg_size_r;
    end
  end

  assign top_hi    = LH_W'(n_eff - CFG_W'(1));
  assign first_bad = ({1'b0, in_data.first_index} >= n_eff);
  assign last_bad  = ({1'b0, in_data.last_index} >= n_eff);
  assign item_bad  = first_bad || (in_data.action == ACT_QUERY && last_bad);
  assign reversed  = (in_data.action == ACT_QUERY) &&
                     (in_data.first_index > in_data.last_index);
  assign item_is_set = (item_r.action == ACT_SET);

  // one shared adder: old/new difference, then node updates or accumulation
  always_comb begin
    if (state_r == S_DIFF) begin
      alu_op = ALU_SUB;
      alu_a  = item_r.new_value;
      alu_b  = elem_q_r;
    end else begin
      alu_op = ALU_ADD;
      alu_a  = item_is_set ? diff_r : acc_r;
      alu_b  = node_q_r;
    end
  end

  stsum_alu u_alu (
    .op (alu_op),
    .a  (alu_a),
    .b  (alu_b),
    .y  (alu_y)
  );

  // walker load: query straight from the accepted beat, set after the diff
  always_comb begin
    w_cmd = '0;
    w_ql  = LH_W'(item_r.first_index);
    w_qr  = LH_W'(item_r.first_index);
    if (accept && !item_bad && !reversed && in_data.action == ACT_QUERY) begin
      w_cmd.load = 1'b1;
      w_cmd.mode = WALK_QUERY;
      w_ql       = LH_W'(in_data.first_index);
      w_qr       = LH_W'(in_data.last_index);
    end else if (state_r == S_DIFF) begin
      w_cmd.load = 1'b1;
      w_cmd.mode = WALK_PATH;
    end
  end

  stsum_walk #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_walk (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (w_cmd),
    .ql     (w_ql),
    .qr     (w_qr),
    .top_hi (top_hi),
    .stat   (w_stat),
    .node   (w_node)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    item_nxt      = item_r;
    diff_nxt      = diff_r;
    acc_nxt       = acc_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    case (state_r)
      S_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + K_W'(1);
        if (clr_cnt_r == K_W'(NODE_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          item_nxt = in_data;
          acc_nxt  = '0;
          if (item_bad || reversed) begin
            // flagged or empty range: answer at once, tree untouched
            out_valid_nxt          = 1'b1;
            out_data_nxt.range_sum = '0;
            out_data_nxt.bad_index = item_bad;
          end else if (in_data.action == ACT_SET) begin
            state_nxt = S_DIFF;
          end else begin
            state_nxt = S_WALK;
          end
        end
      end
      S_DIFF: begin
        diff_nxt  = alu_y;
        state_nxt = S_WALK;
      end
      S_WALK: begin
        if (rd_vld_r && !item_is_set) begin
          acc_nxt = alu_y;
        end
        if (w_stat.last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // fold in the last read beat, then strobe the result
        out_valid_nxt          = 1'b1;
        out_data_nxt.bad_index = 1'b0;
        if (item_is_set) begin
          out_data_nxt.range_sum = '0;
        end else begin
          out_data_nxt.range_sum = rd_vld_r ? alu_y : acc_r;
        end
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      cfg_size_r  <= CFG_W'(MAX_ELEMENTS);
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      rd_vld_r    <= w_stat.emit;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        cfg_size_r <= cfg_wdata;
      end
    end
    item_r     <= item_nxt;
    diff_r     <= diff_nxt;
    acc_r      <= acc_nxt;
    out_data_r <= out_data_nxt;
    wr_addr_r  <= w_node;
  end

  // element store: cleared during the sweep, read on accept, written in S_DIFF
  always_ff @(posedge clk) begin
    if (state_r == S_CLEAR) begin
      if (clr_cnt_r < K_W'(MAX_ELEMENTS)) begin
        elem_mem[clr_cnt_r[LH_W-1:0]] <= '0;
      end
    end else if (state_r == S_DIFF) begin
      elem_mem[LH_W'(item_r.first_index)] <= item_r.new_value;
    end
    if (accept) begin
      elem_q_r <= elem_mem[LH_W'(in_data.first_index)];
    end
  end

  // node sums: read a node on each walk step that emits one, write back node + diff a beat later
  always_ff @(posedge clk) begin
    if (state_r == S_CLEAR) begin
      node_mem[clr_cnt_r] <= '0;
    end else if (rd_vld_r && item_is_set) begin
      node_mem[wr_addr_r] <= alu_y;
    end
    if (w_stat.emit) begin
      node_q_r <= node_mem[w_node];
    end
  end

endmodule

/* sv/stsum_alu.sv */
// Shared 32-bit add/subtract unit of the segment tree block.
// Depends on stsum_pkg.
module stsum_alu (
  input  stsum_pkg::alu_op_t            op,
  input  logic [stsum_pkg::DATA_W-1:0]  a,
  input  logic [stsum_pkg::DATA_W-1:0]  b,
  output logic [stsum_pkg::DATA_W-1:0]  y
);
  import stsum_pkg::*;

  always_comb begin
    case (op)
      ALU_SUB: y = a - b;
      default: y = a + b;
    endcase
  end

endmodule

/* sv/stsum_walk.sv */
// Tree index sequencer: one node range per cycle, leaf path or range cover.
// Depends on stsum_pkg.
module stsum_walk #(
  parameter int MAX_ELEMENTS = stsum_pkg::MAX_ELEMENTS_DEF,
  localparam int LH_W = $clog2(MAX_ELEMENTS),
  localparam int K_W  = LH_W + 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  stsum_pkg::walk_cmd_t   cmd,
  input  logic [LH_W-1:0]        ql,
  input  logic [LH_W-1:0]        qr,
  input  logic [LH_W-1:0]        top_hi,
  output stsum_pkg::walk_stat_t  stat,
  output logic [K_W-1:0]         node
);
  import stsum_pkg::*;

  typedef enum logic [4:0] {
    W_IDLE  = 5'b00001,
    W_PATH  = 5'b00010,
    W_DESC  = 5'b00100,
    W_LEFT  = 5'b01000,
    W_RIGHT = 5'b10000
  } walk_ph_t;

  walk_ph_t        ph_r, ph_nxt;
  logic [LH_W-1:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic [K_W-1:0]  k_r, k_nxt;
  logic [LH_W-1:0] sv_lo_r, sv_lo_nxt, sv_hi_r, sv_hi_nxt;
  logic [K_W-1:0]  sv_k_r, sv_k_nxt;
  logic [LH_W-1:0] ql_r, ql_nxt, qr_r, qr_nxt;

  logic [LH_W-1:0] mid;
  logic [K_W-1:0]  kl, kr;

  assign mid = lo_r + ((hi_r - lo_r) >> 1);
  assign kl  = {k_r[K_W-2:0], 1'b1};
  assign kr  = kl + K_W'(1);

  always_comb begin
    ph_nxt    = ph_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    k_nxt     = k_r;
    sv_lo_nxt = sv_lo_r;
    sv_hi_nxt = sv_hi_r;
    sv_k_nxt  = sv_k_r;
    ql_nxt    = ql_r;
    qr_nxt    = qr_r;
    stat      = '0;
    node      = k_r;
    case (ph_r)
      W_PATH: begin
        stat.emit = 1'b1;
        if (lo_r >= hi_r) begin
          stat.last = 1'b1;
          ph_nxt    = W_IDLE;
        end else if (qr_r <= mid) begin
          hi_nxt = mid;
          k_nxt  = kl;
        end else begin
          lo_nxt = mid + LH_W'(1);
          k_nxt  = kr;
        end
      end
      W_DESC: begin
        if (ql_r <= lo_r && qr_r >= hi_r) begin
          stat.emit = 1'b1;
          stat.last = 1'b1;
          ph_nxt    = W_IDLE;
        end else if (qr_r <= mid) begin
          hi_nxt = mid;
          k_nxt  = kl;
        end else if (ql_r > mid) begin
          lo_nxt = mid + LH_W'(1);
          k_nxt  = kr;
        end else begin
          // split node: park the right child, walk the left boundary first
          sv_lo_nxt = mid + LH_W'(1);
          sv_hi_nxt = hi_r;
          sv_k_nxt  = kr;
          hi_nxt    = mid;
          k_nxt     = kl;
          ph_nxt    = W_LEFT;
        end
      end
      W_LEFT: begin
        if (ql_r <= lo_r) begin
          stat.emit = 1'b1;
          lo_nxt    = sv_lo_r;
          hi_nxt    = sv_hi_r;
          k_nxt     = sv_k_r;
          ph_nxt    = W_RIGHT;
        end else if (ql_r <= mid) begin
          stat.emit = 1'b1;
          node      = kr;
          hi_nxt    = mid;
          k_nxt     = kl;
        end else begin
          lo_nxt = mid + LH_W'(1);
          k_nxt  = kr;
        end
      end
      W_RIGHT: begin
        if (qr_r >= hi_r) begin
          stat.emit = 1'b1;
          stat.last = 1'b1;
          ph_nxt    = W_IDLE;
        end else if (qr_r > mid) begin
          stat.emit = 1'b1;
          node      = kl;
          lo_nxt    = mid + LH_W'(1);
          k_nxt     = kr;
        end else begin
          hi_nxt = mid;
          k_nxt  = kl;
        end
      end
      default: ;
    endcase
    if (cmd.load) begin
      lo_nxt = '0;
      hi_nxt = top_hi;
      k_nxt  = '0;
      ql_nxt = ql;
      qr_nxt = qr;
      ph_nxt = (cmd.mode == WALK_PATH) ? W_PATH : W_DESC;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= W_IDLE;
    end else begin
      ph_r <= ph_nxt;
    end
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    k_r     <= k_nxt;
    sv_lo_r <= sv_lo_nxt;
    sv_hi_r <= sv_hi_nxt;
    sv_k_r  <= sv_k_nxt;
    ql_r    <= ql_nxt;
    qr_r    <= qr_nxt;
  end

endmodule
